FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define RKST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Checked on every rising clock edge, reset included.
`define RKST_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/rkst_pkg.sv
// ----------------------------------------------------------------------------
// rkst_pkg
// Types, widths and codes shared by the sorted ratio list.
// ----------------------------------------------------------------------------
package rkst_pkg;

   localparam int LIST_DEPTH    = 32;
   localparam int FRACTION_BITS = 8;

   localparam int TAG_W     = 16;
   localparam int SHOTS_W   = 16;
   localparam int PTS_W     = 18;
   localparam int KEY_W     = 18;
   localparam int RIDX_W    = 5;
   localparam int POS_W     = 5;
   localparam int FILLED_W  = 6;

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   localparam logic [KEY_W-1:0] THRESHOLD_RESET = KEY_W'(5 << FRACTION_BITS);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_ZERO   = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [TAG_W-1:0]   player_tag;
      logic [SHOTS_W-1:0] shots_taken;
      logic [PTS_W-1:0]   points_per_game;
      logic [RIDX_W-1:0]  read_index;
   } cmd_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [SHOTS_W-1:0] shots;
      logic [PTS_W-1:0]   points;
      logic [KEY_W-1:0]   key;
   } entry_type;

   typedef struct packed {
      logic                accepted;
      logic [POS_W-1:0]    insert_position;
      logic                div_error;
      logic [FILLED_W-1:0] filled_count;
      logic [TAG_W-1:0]    entry_tag;
      logic [SHOTS_W-1:0]  entry_shots;
      logic [PTS_W-1:0]    entry_points;
      logic [KEY_W-1:0]    entry_ratio;
      logic                entry_valid;
   } rsp_type;

endpackage

FILE: design/rkst_front.sv
// ----------------------------------------------------------------------------
// rkst_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rkst_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          command,
   input  logic [rkst_pkg::TAG_W-1:0]    player_tag,
   input  logic [rkst_pkg::SHOTS_W-1:0]  shots_taken,
   input  logic [rkst_pkg::PTS_W-1:0]    points_per_game,
   input  logic [rkst_pkg::RIDX_W-1:0]   read_index,
   output logic                          cmd_valid,
   output rkst_pkg::cmd_type             cmd,
   input  logic                          cmd_take
);

   rkst_pkg::cmd_type slot_ff [2];
   rkst_pkg::cmd_type incoming;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push_ok;
   logic              take_ok;

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push_ok   = push && !full;
   assign take_ok   = cmd_take && cmd_valid;

   always_comb begin
      incoming.player_tag      = player_tag;
      incoming.shots_taken     = shots_taken;
      incoming.points_per_game = points_per_game;
      incoming.read_index      = read_index;
      if (command) begin
         incoming.op = rkst_pkg::OP_READ;
      end else if (shots_taken == '0) begin
         incoming.op = rkst_pkg::OP_ZERO;
      end else begin
         incoming.op = rkst_pkg::OP_INSERT;
      end
   end

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, take_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

FILE: design/rkst_divider.sv
// ----------------------------------------------------------------------------
// rkst_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rkst_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rkst_pkg::PTS_W-1:0]    dividend,
   input  logic [rkst_pkg::SHOTS_W-1:0]  divisor,
   output logic                          done,
   output logic [rkst_pkg::PTS_W-1:0]    quotient
);

   localparam int STEP_W = $clog2(rkst_pkg::PTS_W + 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [rkst_pkg::SHOTS_W-1:0] rem_ff, rem_in;
   logic [rkst_pkg::SHOTS_W-1:0] dsr_ff, dsr_in;
   logic [rkst_pkg::PTS_W-1:0]   quo_ff, quo_in;
   logic [rkst_pkg::SHOTS_W:0]   trial;
   logic [rkst_pkg::SHOTS_W:0]   diff;
   logic                         fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   assign trial = {rem_ff, quo_ff[rkst_pkg::PTS_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[rkst_pkg::SHOTS_W-1:0] : trial[rkst_pkg::SHOTS_W-1:0];
         quo_in  = {quo_ff[rkst_pkg::PTS_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(rkst_pkg::PTS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

endmodule

FILE: design/rkst_back.sv
// ----------------------------------------------------------------------------
// rkst_back
// Executes queued commands against the sorted list and holds the result.
// ----------------------------------------------------------------------------
module rkst_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rkst_pkg::KEY_W-1:0]   threshold,
   input  logic                         cmd_valid,
   input  rkst_pkg::cmd_type            cmd,
   output logic                         cmd_take,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output rkst_pkg::rsp_type            rsp
);

   localparam int DEPTH = rkst_pkg::LIST_DEPTH;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;
   localparam logic [1:0] S_POS  = 2'd3;

   logic [1:0]                     state_ff, state_in;
   rkst_pkg::entry_type            entry_ff [DEPTH];
   rkst_pkg::entry_type            entry_in [DEPTH];
   logic [DEPTH-1:0]               valid_ff, valid_in;
   logic [DEPTH-1:0]               ge_ff, ge_in;
   logic [rkst_pkg::CNT_W-1:0]     occ_ff, occ_in;
   rkst_pkg::cmd_type              cur_ff, cur_in;
   logic [rkst_pkg::KEY_W-1:0]     key_ff, key_in;
   rkst_pkg::rsp_type              res_ff, res_in;
   logic                           res_valid_ff, res_valid_in;

   logic                           div_start;
   logic                           div_done;
   logic [rkst_pkg::PTS_W-1:0]     div_quotient;
   logic [DEPTH:0]                 boundary;
   logic [rkst_pkg::CNT_W-1:0]     pos;
   logic                           list_full;
   logic [rkst_pkg::IDX_W-1:0]     rd_idx;
   logic                           rd_in_range;
   rkst_pkg::entry_type            new_entry;

   assign rsp       = res_ff;
   assign rsp_empty = !res_valid_ff;
   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid && (!res_valid_ff || rsp_pop);
   assign div_start = cmd_take && (cmd.op == rkst_pkg::OP_INSERT);

   rkst_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cmd.points_per_game),
      .divisor  (cmd.shots_taken),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // The compare vector is a run of ones from the head, so the insert
   // position is where that run ends.
   always_comb begin
      boundary[0] = !ge_ff[0];
      for (int k = 1; k < DEPTH; k++) begin
         boundary[k] = ge_ff[k-1] && !ge_ff[k];
      end
      boundary[DEPTH] = ge_ff[DEPTH-1];
      pos = '0;
      for (int k = 0; k <= DEPTH; k++) begin
         pos = pos | ({rkst_pkg::CNT_W{boundary[k]}} & rkst_pkg::CNT_W'(k));
      end
   end

   assign list_full   = boundary[DEPTH];
   assign rd_idx      = rkst_pkg::IDX_W'(cmd.read_index);
   assign rd_in_range = (int'(cmd.read_index) < DEPTH);

   always_comb begin
      new_entry.tag    = cur_ff.player_tag;
      new_entry.shots  = cur_ff.shots_taken;
      new_entry.points = cur_ff.points_per_game;
      new_entry.key    = key_ff;
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      ge_in        = ge_ff;
      occ_in       = occ_ff;
      cur_in       = cur_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !rsp_pop;
      for (int k = 0; k < DEPTH; k++) begin
         entry_in[k] = entry_ff[k];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_take) begin
               cur_in = cmd;
               res_in = '0;
               res_in.filled_count = rkst_pkg::FILLED_W'(occ_ff);
               unique case (cmd.op)
                  rkst_pkg::OP_READ: begin
                     res_valid_in = 1'b1;
                     if (rd_in_range && valid_ff[rd_idx]) begin
                        res_in.entry_tag    = entry_ff[rd_idx].tag;
                        res_in.entry_shots  = entry_ff[rd_idx].shots;
                        res_in.entry_points = entry_ff[rd_idx].points;
                        res_in.entry_ratio  = entry_ff[rd_idx].key;
                        res_in.entry_valid  = 1'b1;
                     end
                  end
                  rkst_pkg::OP_ZERO: begin
                     res_valid_in     = 1'b1;
                     res_in.div_error = 1'b1;
                  end
                  rkst_pkg::OP_INSERT: begin
                     state_in = S_DIV;
                  end
                  default: begin
                     res_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (div_quotient > threshold) begin
                  key_in   = div_quotient;
                  state_in = S_CMP;
               end else begin
                  res_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         S_CMP: begin
            for (int k = 0; k < DEPTH; k++) begin
               ge_in[k] = valid_ff[k] && (entry_ff[k].key >= key_ff);
            end
            state_in = S_POS;
         end
         S_POS: begin
            if (!list_full) begin
               for (int k = 0; k < DEPTH; k++) begin
                  if (boundary[k]) begin
                     entry_in[k] = new_entry;
                     valid_in[k] = 1'b1;
                  end else if (!ge_ff[k] && k > 0) begin
                     entry_in[k] = entry_ff[(k > 0) ? k - 1 : 0];
                     valid_in[k] = valid_ff[(k > 0) ? k - 1 : 0];
                  end
               end
               if (occ_ff != rkst_pkg::CNT_W'(DEPTH)) begin
                  occ_in = occ_ff + 1'b1;
               end
               res_in.accepted        = 1'b1;
               res_in.insert_position = rkst_pkg::POS_W'(pos);
            end
            res_in.filled_count = rkst_pkg::FILLED_W'(occ_in);
            res_valid_in        = 1'b1;
            state_in            = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         occ_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         entry_ff[k] <= entry_in[k];
      end
      ge_ff  <= ge_in;
      cur_ff <= cur_in;
      key_ff <= key_in;
      res_ff <= res_in;
   end

endmodule

FILE: design/ratio_keyed_sorted_top_list_top.sv
// ----------------------------------------------------------------------------
// ratio_keyed_sorted_top_list_top
// Sorted top list of records keyed by points per shot.
// ----------------------------------------------------------------------------
// Requests enter through a queue interface: a transfer happens when req_push
// is high and req_full is low. A request either inserts a record or reads one
// list entry. Results leave through a queue interface: the oldest result is
// on the rsp_ ports while rsp_empty is low, and a transfer happens when
// rsp_pop is high and rsp_empty is low. The threshold register is written by
// a transfer on the csr_ channel, which is always ready.
// A read or a zero shot count is answered by the back end from its idle
// state. An insert runs the radix-2 divider, one quotient bit per cycle over
// 18 bits; a key above the threshold then passes the compare and position
// states. One request is executed at a time, while the two-entry request
// queue keeps accepting.
// Reset empties the list, clears both queues and restores a threshold of
// 1280. When the receiver stalls, the finished result is held, the back end
// waits, and the request queue fills up until req_full rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ratio_keyed_sorted_top_list_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_command,
   input  logic [rkst_pkg::TAG_W-1:0]    req_player_tag,
   input  logic [rkst_pkg::SHOTS_W-1:0]  req_shots_taken,
   input  logic [rkst_pkg::PTS_W-1:0]    req_points_per_game,
   input  logic [rkst_pkg::RIDX_W-1:0]   req_read_index,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_accepted,
   output logic [rkst_pkg::POS_W-1:0]    rsp_insert_position,
   output logic                          rsp_div_error,
   output logic [rkst_pkg::FILLED_W-1:0] rsp_filled_count,
   output logic [rkst_pkg::TAG_W-1:0]    rsp_entry_tag,
   output logic [rkst_pkg::SHOTS_W-1:0]  rsp_entry_shots,
   output logic [rkst_pkg::PTS_W-1:0]    rsp_entry_points,
   output logic [rkst_pkg::KEY_W-1:0]    rsp_entry_ratio,
   output logic                          rsp_entry_valid,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rkst_pkg::KEY_W-1:0]    csr_wdata
);

   logic [rkst_pkg::KEY_W-1:0] thresh_ff, thresh_in;
   logic                       cmd_valid;
   logic                       cmd_take;
   rkst_pkg::cmd_type          cmd;
   rkst_pkg::rsp_type          rsp;
   logic                       accept_shown;
   logic                       accept_clean;
   logic                       entry_shown;
   logic                       entry_clean;
   logic                       fill_in_range;

   assign csr_ready = 1'b1;
   assign thresh_in = (csr_valid && csr_ready) ? csr_wdata : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= rkst_pkg::THRESHOLD_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   rkst_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (req_push),
      .full            (req_full),
      .command         (req_command),
      .player_tag      (req_player_tag),
      .shots_taken     (req_shots_taken),
      .points_per_game (req_points_per_game),
      .read_index      (req_read_index),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take)
   );

   rkst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .threshold (thresh_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_accepted        = rsp.accepted;
   assign rsp_insert_position = rsp.insert_position;
   assign rsp_div_error       = rsp.div_error;
   assign rsp_filled_count    = rsp.filled_count;
   assign rsp_entry_tag       = rsp.entry_tag;
   assign rsp_entry_shots     = rsp.entry_shots;
   assign rsp_entry_points    = rsp.entry_points;
   assign rsp_entry_ratio     = rsp.entry_ratio;
   assign rsp_entry_valid     = rsp.entry_valid;

   assign accept_shown  = !rsp_empty && rsp_accepted;
   assign accept_clean  = !rsp_div_error && !rsp_entry_valid && (rsp_filled_count != '0);
   assign entry_shown   = !rsp_empty && rsp_entry_valid;
   assign entry_clean   = (rsp_entry_ratio != '0) && !rsp_div_error;
   assign fill_in_range = (int'(rsp_filled_count) <= rkst_pkg::LIST_DEPTH);

   `RKST_ASSERT(a_empty_after_reset, clock, reset, $past(reset) |-> rsp_empty, "result after reset")
   `RKST_ASSERT(a_accept_excl, clock, reset, accept_shown |-> accept_clean, "bad insert result")
   `RKST_ASSERT(a_valid_key, clock, reset, entry_shown |-> entry_clean, "valid entry without a key")
   `RKST_ASSERT(a_fill_bound, clock, reset, !rsp_empty |-> fill_in_range, "filled count above depth")

endmodule

FILE: sim/tb_ratio_keyed_sorted_top_list_top.sv
// ----------------------------------------------------------------------------
// tb_ratio_keyed_sorted_top_list_top
// Self-checking testbench for the sorted top list keyed by points per shot.
// ----------------------------------------------------------------------------
// A driver pushes insert and read requests in random bursts, and a receiver
// pops results on its own stall pattern. Every accepted request is run through
// a cycle-free model of the list, and each popped result is compared field by
// field against the oldest prediction. A directed set covers boundary keys,
// ties, zero shot counts and reads of empty entries. Random phases then run
// under several threshold settings, from zero up to the largest value.
// ----------------------------------------------------------------------------
module tb_ratio_keyed_sorted_top_list_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rkst_pkg::*;

   localparam bit CMD_INSERT = 1'b0;
   localparam bit CMD_READ   = 1'b1;

   localparam int unsigned PTS_MAX    = (1 << PTS_W) - 1;
   localparam int unsigned SHOTS_MAX  = (1 << SHOTS_W) - 1;
   localparam int unsigned KEY_MAX    = (1 << KEY_W) - 1;
   localparam int          PHASES     = 7;
   localparam int          PHASE_REQS = 205;
   localparam int          IDLE_LIMIT = 2000;
   localparam int          TAIL_WAIT  = 30;

   typedef struct packed {
      logic               command;
      logic [TAG_W-1:0]   tag;
      logic [SHOTS_W-1:0] shots;
      logic [PTS_W-1:0]   points;
      logic [RIDX_W-1:0]  read_index;
   } req_item;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic                req_command = 1'b0;
   logic [TAG_W-1:0]    req_player_tag = '0;
   logic [SHOTS_W-1:0]  req_shots_taken = '0;
   logic [PTS_W-1:0]    req_points_per_game = '0;
   logic [RIDX_W-1:0]   req_read_index = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic                rsp_accepted;
   logic [POS_W-1:0]    rsp_insert_position;
   logic                rsp_div_error;
   logic [FILLED_W-1:0] rsp_filled_count;
   logic [TAG_W-1:0]    rsp_entry_tag;
   logic [SHOTS_W-1:0]  rsp_entry_shots;
   logic [PTS_W-1:0]    rsp_entry_points;
   logic [KEY_W-1:0]    rsp_entry_ratio;
   logic                rsp_entry_valid;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [KEY_W-1:0]    csr_wdata = '0;

   ratio_keyed_sorted_top_list_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_command         (req_command),
      .req_player_tag      (req_player_tag),
      .req_shots_taken     (req_shots_taken),
      .req_points_per_game (req_points_per_game),
      .req_read_index      (req_read_index),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_accepted        (rsp_accepted),
      .rsp_insert_position (rsp_insert_position),
      .rsp_div_error       (rsp_div_error),
      .rsp_filled_count    (rsp_filled_count),
      .rsp_entry_tag       (rsp_entry_tag),
      .rsp_entry_shots     (rsp_entry_shots),
      .rsp_entry_points    (rsp_entry_points),
      .rsp_entry_ratio     (rsp_entry_ratio),
      .rsp_entry_valid     (rsp_entry_valid),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_wdata           (csr_wdata)
   );

   always #10 clock = ~clock;

   // Model of the list contents and the threshold register.
   logic [KEY_W-1:0]   list_key    [LIST_DEPTH];
   logic [TAG_W-1:0]   list_tag    [LIST_DEPTH];
   logic [SHOTS_W-1:0] list_shots  [LIST_DEPTH];
   logic [PTS_W-1:0]   list_points [LIST_DEPTH];
   int unsigned        list_fill = 0;
   logic [KEY_W-1:0]   list_threshold = THRESHOLD_RESET;

   req_item pending_reqs[$];
   rsp_type predicted_rsps[$];
   req_item cur_req = '0;
   bit      req_presented = 1'b0;
   bit      req_taken = 1'b0;
   int      burst_left = 0;
   int      gap_left = 0;
   int      queued_count = 0;
   int      accepted_count = 0;
   bit      rx_popping = 1'b1;
   int      rx_left = 0;
   int      field_errors = 0;
   int      results_seen = 0;
   int      idle_cycles = 0;

   function automatic rsp_type apply_to_list(req_item r);
      rsp_type          res;
      logic [KEY_W-1:0] key;
      int               pos;
      int               k;
      res = '0;
      if (r.command == CMD_READ) begin
         if (r.read_index < LIST_DEPTH) begin
            res.entry_tag    = list_tag[r.read_index];
            res.entry_shots  = list_shots[r.read_index];
            res.entry_points = list_points[r.read_index];
            res.entry_ratio  = list_key[r.read_index];
            res.entry_valid  = (list_key[r.read_index] != '0);
         end
      end else if (r.shots == '0) begin
         res.div_error = 1'b1;
      end else begin
         key = r.points / r.shots;
         if (key > list_threshold) begin
            pos = 0;
            while (pos < LIST_DEPTH && list_key[pos] >= key) pos++;
            if (pos < LIST_DEPTH) begin
               for (k = LIST_DEPTH - 1; k > pos; k--) begin
                  list_key[k]    = list_key[k-1];
                  list_tag[k]    = list_tag[k-1];
                  list_shots[k]  = list_shots[k-1];
                  list_points[k] = list_points[k-1];
               end
               list_key[pos]    = key;
               list_tag[pos]    = r.tag;
               list_shots[pos]  = r.shots;
               list_points[pos] = r.points;
               if (list_fill < LIST_DEPTH) list_fill++;
               res.accepted        = 1'b1;
               res.insert_position = POS_W'(pos);
            end
         end
      end
      res.filled_count = FILLED_W'(list_fill);
      return res;
   endfunction

   function automatic req_item make_req(bit cmd, int unsigned tag, int unsigned shots,
                                        int unsigned pts, int unsigned ridx);
      req_item r;
      r.command    = cmd;
      r.tag        = TAG_W'(tag);
      r.shots      = SHOTS_W'(shots);
      r.points     = PTS_W'(pts);
      r.read_index = RIDX_W'(ridx);
      return r;
   endfunction

   // Builds an insert whose key lands near, on or above the threshold.
   function automatic req_item make_insert(int unsigned thr);
      int          key;
      int unsigned cap;
      int unsigned shots;
      int unsigned base;
      int unsigned slack;
      case ($urandom_range(0, 9))
         0, 1:    key = int'(thr) + int'($urandom_range(0, 6)) - 3;
         2:       key = int'(thr) + 1 + int'($urandom_range(0, 3)) * 7;
         default: key = int'(thr) + 1 + int'($urandom_range(0, 1 << $urandom_range(0, 17)));
      endcase
      if (key < 0) key = 0;
      if (key > int'(KEY_MAX)) key = int'(KEY_MAX);
      cap = (key == 0) ? SHOTS_MAX : PTS_MAX / key;
      if (cap > SHOTS_MAX) cap = SHOTS_MAX;
      if (cap == 0) cap = 1;
      if ($urandom_range(0, 3) == 0) shots = $urandom_range(1, cap);
      else shots = $urandom_range(1, (cap < 64) ? cap : 64);
      base  = key * shots;
      slack = PTS_MAX - base;
      if (slack > shots - 1) slack = shots - 1;
      return make_req(CMD_INSERT, $urandom, shots, base + $urandom_range(0, slack), $urandom);
   endfunction

   function automatic req_item make_random_req(int unsigned thr);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return make_req(CMD_READ, $urandom, $urandom, $urandom, $urandom);
      if (pick < 35) return make_req(CMD_INSERT, $urandom, 0, $urandom, $urandom);
      if (pick < 45) return make_req(1'($urandom), $urandom, $urandom, $urandom, $urandom);
      return make_insert(thr);
   endfunction

   task automatic queue_req(req_item r);
      pending_reqs.push_back(r);
      queued_count++;
   endtask

   task automatic wait_all_done();
      while (accepted_count != queued_count || predicted_rsps.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_threshold(logic [KEY_W-1:0] value);
      @(negedge clock);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      list_threshold = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         field_errors++;
         if (field_errors <= 10)
            $display("Result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
      end
   endtask

   // Request driver.
   always @(negedge clock) begin
      if (req_taken) begin
         req_presented = 1'b0;
         req_taken     = 1'b0;
      end
      if (!req_presented) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0) begin
            cur_req       = pending_reqs.pop_front();
            req_presented = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                        : $urandom_range(0, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
         end
      end
      req_push            <= req_presented;
      req_command         <= cur_req.command;
      req_player_tag      <= cur_req.tag;
      req_shots_taken     <= cur_req.shots;
      req_points_per_game <= cur_req.points;
      req_read_index      <= cur_req.read_index;
   end

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         predicted_rsps.push_back(apply_to_list(cur_req));
         req_taken = 1'b1;
         accepted_count++;
      end
   end

   // Result receiver with its own run and stall lengths.
   always @(negedge clock) begin
      if (rx_left > 0) begin
         rx_left--;
      end else begin
         rx_popping = !rx_popping;
         if (rx_popping) rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                               : $urandom_range(1, 30);
         else rx_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(0, 5);
      end
      rsp_pop <= rx_popping;
   end

   // Result monitor.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (predicted_rsps.size() == 0) begin
            field_errors++;
            if (field_errors <= 10)
               $display("Result %0d arrived with no prediction pending", results_seen);
         end else begin
            want = predicted_rsps.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
            check_field("insert_position", 32'(want.insert_position),
                        32'(rsp_insert_position));
            check_field("div_error", 32'(want.div_error), 32'(rsp_div_error));
            check_field("filled_count", 32'(want.filled_count), 32'(rsp_filled_count));
            check_field("entry_tag", 32'(want.entry_tag), 32'(rsp_entry_tag));
            check_field("entry_shots", 32'(want.entry_shots), 32'(rsp_entry_shots));
            check_field("entry_points", 32'(want.entry_points), 32'(rsp_entry_points));
            check_field("entry_ratio", 32'(want.entry_ratio), 32'(rsp_entry_ratio));
            check_field("entry_valid", 32'(want.entry_valid), 32'(rsp_entry_valid));
         end
      end
   end

   // The watchdog ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int ph;
      int n;
      logic [KEY_W-1:0] thr;
      for (n = 0; n < LIST_DEPTH; n++) begin
         list_key[n]    = '0;
         list_tag[n]    = '0;
         list_shots[n]  = '0;
         list_points[n] = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_req(make_req(CMD_READ, 0, 0, 0, 0));
      queue_req(make_req(CMD_READ, SHOTS_MAX, SHOTS_MAX, PTS_MAX, LIST_DEPTH - 1));
      queue_req(make_req(CMD_INSERT, 1, 0, PTS_MAX, 0));
      queue_req(make_req(CMD_INSERT, 2, 0, 0, LIST_DEPTH - 1));
      queue_req(make_req(CMD_INSERT, 3, 1, 32'(THRESHOLD_RESET), 0));
      queue_req(make_req(CMD_INSERT, 4, 1, THRESHOLD_RESET + 1, 0));
      queue_req(make_req(CMD_INSERT, 5, SHOTS_MAX, PTS_MAX, 0));
      queue_req(make_req(CMD_INSERT, SHOTS_MAX, 1, PTS_MAX, LIST_DEPTH - 1));
      queue_req(make_req(CMD_INSERT, 0, 1, PTS_MAX, 0));
      queue_req(make_req(CMD_INSERT, 6, 2, PTS_MAX, 0));
      queue_req(make_req(CMD_INSERT, 7, 3, 4000, 0));
      queue_req(make_req(CMD_INSERT, 8, 1, 0, 0));
      queue_req(make_req(CMD_INSERT, 9, 200, 256300, 0));
      queue_req(make_req(CMD_INSERT, 10, SHOTS_MAX, 0, 0));
      for (n = 0; n < 6; n++) queue_req(make_req(CMD_READ, n, n, n, n));
      queue_req(make_req(CMD_READ, 0, 0, 0, LIST_DEPTH - 1));

      for (ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            case (ph)
               1:       thr = '0;
               2:       thr = KEY_W'(KEY_MAX);
               3:       thr = KEY_W'(1 << FRACTION_BITS);
               4:       thr = KEY_W'($urandom_range(0, 4000));
               5:       thr = KEY_W'($urandom_range(0, KEY_MAX));
               default: thr = THRESHOLD_RESET;
            endcase
            wait_all_done();
            write_threshold(thr);
         end
         for (n = 0; n < PHASE_REQS; n++) queue_req(make_random_req(32'(list_threshold)));
      end

      wait_all_done();
      repeat (TAIL_WAIT) @(posedge clock);
      if (field_errors == 0 && predicted_rsps.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
